FILE: sv/sipq_pkg.sv
// shared constants, codes and types for the sorted insert priority queue
package sipq_pkg;

    localparam int DEPTH      = 16;
    localparam int KEY_W      = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CAP_W      = 5;
    localparam int COUNT_W    = 5;
    localparam int STATUS_W   = 2;
    localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int IN_TDATA_W = ((KEY_W + 7) / 8) * 8;
    localparam int OUT_RAW_W  = KEY_W + COUNT_W;
    localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // per-cell control from the top level
    typedef struct packed {
        logic occ;       // cell lies below the held count
        logic at_count;  // cell is the first free slot
        logic do_ins;    // accepted insert that goes ahead
        logic do_rem;    // accepted remove that goes ahead
    } t_cell_ctl;

endpackage

FILE: sv/sipq_cell.sv
// one cell of the sorted chain: holds a key and shifts with its neighbours
module sipq_cell
    import sipq_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [KEY_W-1:0] i_new_key,
    input  logic             i_prev_sel,
    input  logic [KEY_W-1:0] i_prev_key,
    input  logic [KEY_W-1:0] i_next_key,
    output logic             o_sel,
    output logic [KEY_W-1:0] o_key
);

    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] n_key;

    // at or above the insert point: larger held key, or the first free slot
    assign o_sel = (i_ctl.occ && (r_key > i_new_key)) || i_ctl.at_count;
    assign o_key = r_key;

    always_comb begin
        n_key = r_key;
        if (i_ctl.do_ins && o_sel) begin
            n_key = i_prev_sel ? i_prev_key : i_new_key;
        end else if (i_ctl.do_rem) begin
            n_key = i_next_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

FILE: sv/sorted_insert_priority_queue_core.sv
// top level of the sorted insert priority queue: cell chain, count and result register
//
// usage
//   input words arrive on the s_axis group: tdata holds the key, tuser the
//   opcode (0 insert, 1 remove smallest). each word yields one result word on
//   the m_axis group: tdata holds removed_key in bits 31:0 and entry_count in
//   bits 36:32, tuser holds the status (0 done, 1 store full, 2 store empty).
//   the cfg channel writes capacity_in_use; it is always ready and should be
//   used only while the queue is idle.
// throughput
//   one word per cycle while m_axis takes each result: every cell compares its
//   key against the incoming key in parallel and shifts to its neighbour in the
//   same cycle, so the result is registered on acceptance and a new word can be
//   taken every cycle. the single compare per cell sets the cycle time.
// reset
//   synchronous active-low reset empties the queue (count zero), sets the
//   capacity to 16 and drops any pending result. cell contents are not reset.
// back-pressure
//   while a result waits in the output register and m_axis tready is low,
//   s_axis tready is low; a result taken in the same cycle frees the slot.
module sorted_insert_priority_queue_core
    import sipq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input words
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // key
    input  logic                   i_s_axis_tuser,   // opcode
    // result words
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // removed_key, entry_count, zero pad
    output logic [STATUS_W-1:0]    o_m_axis_tuser,   // status
    // capacity register write
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CAP_W-1:0]       i_cfg_data
);

    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic [CAP_W-1:0]    r_cap;
    logic                r_out_valid;
    logic [KEY_W-1:0]    r_out_key;
    logic [KEY_W-1:0]    n_out_key;
    t_status             r_out_status;
    t_status             n_out_status;
    logic [CNT_W-1:0]    r_out_count;

    logic                in_acc;
    logic                is_ins;
    logic                full;
    logic                empty;
    logic                do_ins;
    logic                do_rem;
    logic [KEY_W-1:0]    in_key;

    logic [DEPTH-1:0]    sel;
    logic [KEY_W-1:0]    cell_key [DEPTH];
    t_cell_ctl           cell_ctl [DEPTH];

    // input side is free when the result slot is empty or being emptied
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign is_ins          = (t_opcode'(i_s_axis_tuser) == OP_INSERT);
    assign in_key          = i_s_axis_tdata[KEY_W-1:0];
    assign o_cfg_ready     = 1'b1;

    // effective capacity saturates at the chain depth
    assign full  = (CMP_W'(r_count) >= CMP_W'(r_cap)) || (r_count == CNT_W'(DEPTH));
    assign empty = (r_count == '0);

    assign do_ins = in_acc && is_ins && !full;
    assign do_rem = in_acc && !is_ins && !empty;

    // cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign cell_ctl[g].occ      = (CNT_W'(g) < r_count);
        assign cell_ctl[g].at_count = (CNT_W'(g) == r_count);
        assign cell_ctl[g].do_ins   = do_ins;
        assign cell_ctl[g].do_rem   = do_rem;

        sipq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (cell_ctl[g]),
            .i_new_key  (in_key),
            .i_prev_sel ((g == 0) ? 1'b0 : sel[(g == 0) ? 0 : g - 1]),
            .i_prev_key (cell_key[(g == 0) ? 0 : g - 1]),
            .i_next_key (cell_key[(g == DEPTH - 1) ? g : g + 1]),
            .o_sel      (sel[g]),
            .o_key      (cell_key[g])
        );
    end

    always_comb begin
        n_count      = r_count;
        n_out_key    = '0;
        n_out_status = ST_DONE;
        if (is_ins) begin
            if (full) begin
                n_out_status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (empty) begin
                n_out_status = ST_EMPTY;
            end else begin
                n_out_key = cell_key[0];
                n_count   = r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            if (in_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_key    <= n_out_key;
            r_out_status <= n_out_status;
            r_out_count  <= n_count;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'({COUNT_W'(r_out_count), r_out_key});
    assign o_m_axis_tuser  = r_out_status;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("held count exceeds depth");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_ins |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("accepted insert did not grow the count");

    a_remove_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_rem |=> (r_out_key == $past(cell_key[0])) && (r_out_status == ST_DONE))
        else $error("remove did not return the head cell");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_EMPTY)) |-> (r_out_key == '0))
        else $error("empty remove returned a non-zero key");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_ins && full) |=> $stable(r_count))
        else $error("refused insert changed the count");
`endif

endmodule
